// ===== rtl/core/kps_pkg.sv =====
`default_nettype none
package kps_pkg;

	// fixed geometry of the matrix and the remote decoder
	localparam int COLUMN_COUNT = 8;
	localparam int REMOTE_CODES = 15;

	localparam logic [7:0]  LINES_IDLE     = 8'hFF;
	localparam logic [15:0] DEBOUNCE_RESET = 16'd20;
	localparam logic [3:0]  SETTLE_RESET   = 4'd2;
	localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

	// configuration register indexes
	localparam logic [3:0] REG_DEBOUNCE = 4'd0;
	localparam logic [3:0] REG_SETTLE   = 4'd1;

	// scan steps
	localparam logic [2:0] STEP_IDLE        = 3'd0;
	localparam logic [2:0] STEP_SETTLE_LOW  = 3'd1;
	localparam logic [2:0] STEP_DETECT      = 3'd2;
	localparam logic [2:0] STEP_DEBOUNCE    = 3'd3;
	localparam logic [2:0] STEP_CONFIRM     = 3'd4;
	localparam logic [2:0] STEP_SETTLE_HIGH = 3'd5;
	localparam logic [2:0] STEP_CLASSIFY    = 3'd6;
	localparam logic [2:0] STEP_RELEASE     = 3'd7;

	// row drive patterns, bit 0 row one, bit 1 row two
	localparam logic [1:0] ROWS_LOW      = 2'b00;
	localparam logic [1:0] ROWS_TWO_HIGH = 2'b10;

	localparam logic [3:0] REMOTE_TABLE [REMOTE_CODES] = '{
		4'h1, 4'h2, 4'h4, 4'hA, 4'hB, 4'h6, 4'h7, 4'hC,
		4'h9, 4'h3, 4'hE, 4'hD, 4'hF, 4'h8, 4'h5
	};

	typedef struct packed {
		logic [7:0] column_lines;
		logic [3:0] remote_nibble;
		logic       key_taken;
	} tick_t;

	typedef struct packed {
		logic       row_one_drive;
		logic       row_two_drive;
		logic       key_ready;
		logic [4:0] key_value;
		logic       key_from_remote;
	} key_t;

	typedef struct packed {
		logic [2:0]  scan_step;
		logic [15:0] wait_count;
		logic        held_flag;
		logic [4:0]  held_code;
		logic        held_source;
		logic [3:0]  captured_column;
		logic [1:0]  row_levels;
		logic        remote_lock;
		logic [15:0] remote_count;
	} state_t;

	// saturating tick counter
	function automatic logic [15:0] bump(input logic [15:0] v);
		return (v == COUNT_MAX) ? v : v + 16'd1;
	endfunction

	// column number 1..COLUMN_COUNT for a single low line, else 0
	function automatic logic [3:0] column_of(input logic [7:0] lines);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < COLUMN_COUNT; i++) begin
			if (lines == ~(8'd1 << i))
				c = 4'(i + 1);
		end
		return c;
	endfunction

	// remote nibble to code 1..15, 0 when not in the table
	function automatic logic [3:0] remote_code_of(input logic [3:0] nib);
		logic [3:0] c;
		c = '0;
		for (int i = 0; i < REMOTE_CODES; i++) begin
			if (nib == REMOTE_TABLE[i])
				c = 4'(i + 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/kps_tick_if.sv =====
`default_nettype none
interface kps_tick_if;
	logic       valid;
	logic       ready;
	logic [7:0] column_lines;
	logic [3:0] remote_nibble;
	logic       key_taken;

	modport source (output valid, column_lines, remote_nibble, key_taken, input ready);
	modport sink   (input valid, column_lines, remote_nibble, key_taken, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kps_key_if.sv =====
`default_nettype none
interface kps_key_if;
	logic       valid;
	logic       ready;
	logic       row_one_drive;
	logic       row_two_drive;
	logic       key_ready;
	logic [4:0] key_value;
	logic       key_from_remote;

	modport source (output valid, row_one_drive, row_two_drive, key_ready, key_value,
		key_from_remote, input ready);
	modport sink   (input valid, row_one_drive, row_two_drive, key_ready, key_value,
		key_from_remote, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kps_cfg_if.sv =====
`default_nettype none
interface kps_cfg_if;
	logic        valid;
	logic        ready;
	logic [3:0]  index;
	logic [15:0] wdata;

	modport source (output valid, index, wdata, input ready);
	modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/kps_step.sv =====
`default_nettype none
module kps_step (
	input  kps_pkg::state_t cur,
	input  kps_pkg::tick_t  item,
	input  logic [15:0]     debounce,
	input  logic [3:0]      settle,
	output kps_pkg::state_t nxt
);
	import kps_pkg::*;

	logic        idle;
	logic [15:0] wc_inc;
	logic        settle_hit;
	logic [3:0]  col;
	logic [15:0] rc_inc;

	assign idle       = (item.column_lines == LINES_IDLE);
	assign wc_inc     = bump(cur.wait_count);
	assign settle_hit = (wc_inc >= {12'd0, settle});
	assign col        = column_of(item.column_lines);
	assign rc_inc     = bump(cur.remote_count);

	always_comb begin
		nxt = cur;
		if (item.key_taken) begin
			nxt.held_flag   = 1'b0;
			nxt.held_code   = '0;
			nxt.held_source = 1'b0;
		end

		if (!nxt.held_flag) begin
			unique case (cur.scan_step)
				STEP_IDLE: begin
					nxt.row_levels = ROWS_LOW;
					nxt.scan_step  = settle_hit ? STEP_DETECT : STEP_SETTLE_LOW;
					nxt.wait_count = settle_hit ? 16'd0 : wc_inc;
				end
				STEP_SETTLE_LOW: begin
					nxt.scan_step  = settle_hit ? STEP_DETECT : STEP_SETTLE_LOW;
					nxt.wait_count = settle_hit ? 16'd0 : wc_inc;
				end
				STEP_DETECT: begin
					nxt.scan_step = idle ? STEP_IDLE : STEP_DEBOUNCE;
				end
				STEP_DEBOUNCE: begin
					if (cur.wait_count >= debounce) begin
						nxt.wait_count = '0;
						nxt.scan_step  = STEP_CONFIRM;
					end else begin
						nxt.wait_count = wc_inc;
					end
				end
				STEP_CONFIRM: begin
					if (idle) begin
						nxt.scan_step = STEP_IDLE;
					end else begin
						nxt.captured_column = col;
						nxt.row_levels      = ROWS_TWO_HIGH;
						nxt.scan_step  = settle_hit ? STEP_CLASSIFY : STEP_SETTLE_HIGH;
						nxt.wait_count = settle_hit ? 16'd0 : wc_inc;
					end
				end
				STEP_SETTLE_HIGH: begin
					nxt.scan_step  = settle_hit ? STEP_CLASSIFY : STEP_SETTLE_HIGH;
					nxt.wait_count = settle_hit ? 16'd0 : wc_inc;
				end
				STEP_CLASSIFY: begin
					// a key still seen with row two high sits on row one
					if (!idle)
						nxt.held_code = {1'b0, col};
					else if (cur.captured_column != 4'd0)
						nxt.held_code = 5'd8 + {1'b0, cur.captured_column};
					else
						nxt.held_code = '0;
					nxt.held_source = 1'b0;
					nxt.held_flag   = 1'b1;
					nxt.row_levels  = ROWS_LOW;
					nxt.scan_step   = idle ? STEP_IDLE : STEP_RELEASE;
				end
				STEP_RELEASE: begin
					if (idle)
						nxt.scan_step = STEP_IDLE;
				end
			endcase

			if (!nxt.held_flag) begin
				if (item.remote_nibble == 4'd0) begin
					nxt.remote_lock  = 1'b0;
					nxt.remote_count = '0;
				end else if (!cur.remote_lock) begin
					nxt.remote_count = rc_inc;
					if (rc_inc >= debounce) begin
						nxt.remote_lock = 1'b1;
						nxt.held_flag   = 1'b1;
						nxt.held_code   = {1'b0, remote_code_of(item.remote_nibble)};
						nxt.held_source = 1'b1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/matrix_keypad_remote_scanner.sv =====
// Keypad and remote-code scanner, one word per 1 ms tick.
// tick (sink): column levels (active low), remote nibble, key_taken flag.
// key (source): one word per tick word - row drive levels, key_ready,
//   key_value and key_from_remote as they stand after that tick.
// cfg (sink): index 0 debounce ticks, index 1 settle ticks; other indexes
//   are dropped. Always ready; write only while the block is idle.
// Path: an accepted tick word is registered in the input stage, and its key
//   word is then registered in the output stage.
//   Throughput: one word per cycle while key.ready does not stall, set by the
//   single registered next-state pass between the input and output stages.
// Stall: while key.ready is low the output word holds; one more tick word
//   may wait in the input stage, then tick.ready drops.
// Reset (arst_n low): scan at idle step, counters zero, nothing held,
//   rows low, debounce 20, settle 2; both pipeline stages empty.
`default_nettype none
module matrix_keypad_remote_scanner (
	input  wire     clk,
	input  wire     arst_n,
	kps_tick_if.sink   tick,
	kps_key_if.source  key,
	kps_cfg_if.sink    cfg
);
	import kps_pkg::*;

	// input stage
	tick_t       tick_s1;
	logic        valid_s1;
	// scan / hold state, updated as a word leaves stage 1
	state_t      state_q;
	state_t      state_next;
	// output stage
	key_t        key_s2;
	logic        valid_s2;
	// config
	logic [15:0] debounce_q;
	logic [3:0]  settle_q;

	logic        advance;

	assign advance    = valid_s1 && (!valid_s2 || key.ready);
	assign tick.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			settle_q   <= SETTLE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_DEBOUNCE: debounce_q <= cfg.wdata;
				REG_SETTLE:   settle_q   <= cfg.wdata[3:0];
				default: ;
			endcase
		end
	end

	// stage 1 holds the accepted tick word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.valid && tick.ready) begin
			tick_s1.column_lines  <= tick.column_lines;
			tick_s1.remote_nibble <= tick.remote_nibble;
			tick_s1.key_taken     <= tick.key_taken;
		end
	end

	kps_step u_step (
		.cur      (state_q),
		.item     (tick_s1),
		.debounce (debounce_q),
		.settle   (settle_q),
		.nxt      (state_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// stage 2: result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (key.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_s2.row_one_drive   <= state_next.row_levels[0];
			key_s2.row_two_drive   <= state_next.row_levels[1];
			key_s2.key_ready       <= state_next.held_flag;
			key_s2.key_value       <= state_next.held_code;
			key_s2.key_from_remote <= state_next.held_source;
		end
	end

	assign key.valid           = valid_s2;
	assign key.row_one_drive   = key_s2.row_one_drive;
	assign key.row_two_drive   = key_s2.row_two_drive;
	assign key.key_ready       = key_s2.key_ready;
	assign key.key_value       = key_s2.key_value;
	assign key.key_from_remote = key_s2.key_from_remote;

`ifndef SYNTH
	// nothing held means a clean code and source
	a_idle_code: assert property (@(posedge clk) disable iff (!arst_n)
		key.valid && !key.key_ready |-> key.key_value == 5'd0 && !key.key_from_remote)
		else $error("code shown without a held key");

	// row one is never driven high
	a_row_one: assert property (@(posedge clk) disable iff (!arst_n)
		key.valid |-> !key.row_one_drive)
		else $error("row one driven high");

	// a held key that is not taken freezes the scan
	a_hold_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		advance && state_q.held_flag && !tick_s1.key_taken |=>
			$stable(state_q.scan_step) && $stable(state_q.wait_count))
		else $error("scan moved while a key was held");

	// remote codes stay within the table range
	a_remote_range: assert property (@(posedge clk) disable iff (!arst_n)
		key.valid && key.key_from_remote |-> key.key_value <= 5'd15)
		else $error("remote code out of range");
`endif
endmodule
`default_nettype wire
